// File: rtl/crccs_pkg.sv
// Shared types and constants for the CRC codeword stream checker.
package crccs_pkg;

	localparam int BYTE_W     = 8;
	localparam int POLY_W     = 17;
	localparam int DEG_W      = 5;
	localparam int CNT_W      = 32;
	localparam int SKIP_W     = 4;
	localparam int DW_WIDE    = 8;
	localparam int DW_NARROW  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int Q_DEPTH    = 2;
	localparam int Q_AW       = 1;
	localparam int M_TDATA_W  = BYTE_W + 2 * CNT_W;

	localparam logic [CFG_IDX_W-1:0] REG_POLY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DW8    = 2'd2;

	localparam logic [POLY_W-1:0] POLY_RST   = 17'd3;
	localparam logic [DEG_W-1:0]  DEGREE_RST = 5'd1;
	localparam logic              DW8_RST    = 1'b1;

	localparam logic [SKIP_W-1:0] SKIP_NONE  = 4'd0;
	localparam logic [SKIP_W-1:0] SKIP_WHOLE = 4'd8;

	typedef struct packed {
		logic [POLY_W-1:0] poly;
		logic [DEG_W-1:0]  degree;
		logic              dw8;
	} cfg_t;

	typedef struct packed {
		logic              hdr;
		logic [SKIP_W-1:0] skip;
		logic [BYTE_W-1:0] data;
	} q_entry_t;

endpackage

// File: rtl/crccs_front.sv
// Input side: header detection and pad skip tagging of stream bytes.
module crccs_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [crccs_pkg::BYTE_W-1:0] s_tdata,
	input  logic                       s_tuser,
	input  logic                       q_ready,
	output logic                       push,
	output crccs_pkg::q_entry_t        entry
);
	import crccs_pkg::*;

	logic              expect_hdr_q;
	logic [SKIP_W-1:0] skip_q;
	logic              is_hdr;
	logic [SKIP_W-1:0] hdr_skip;

	assign s_tready = q_ready;
	assign push     = s_tvalid && q_ready;
	assign is_hdr   = s_tuser || expect_hdr_q;
	assign hdr_skip = (s_tdata >= BYTE_W'(DW_WIDE)) ? SKIP_WHOLE : SKIP_W'(s_tdata[2:0]);

	always_comb begin
		entry.hdr  = is_hdr;
		entry.skip = is_hdr ? SKIP_NONE : skip_q;
		entry.data = s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_hdr_q <= 1'b1;
			skip_q       <= SKIP_NONE;
		end else if (push) begin
			expect_hdr_q <= 1'b0;
			skip_q       <= is_hdr ? hdr_skip : SKIP_NONE;
		end
	end

endmodule

// File: rtl/crccs_fifo.sv
// Two-entry queue between the input side and the checking side.
module crccs_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  crccs_pkg::q_entry_t din,
	output logic                ready,
	input  logic                pop,
	output crccs_pkg::q_entry_t dout,
	output logic                valid
);
	import crccs_pkg::*;

	q_entry_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_AW:0]     count_q;

	assign ready = count_q != (Q_AW+1)'(Q_DEPTH);
	assign valid = count_q != '0;
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			if (push && !pop)
				count_q <= count_q + (Q_AW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (Q_AW+1)'(1);
		end
	end

endmodule

// File: rtl/crccs_back.sv
// Checking side: serial CRC division, codeword cutting, byte packing, counters.
module crccs_back #(
	parameter int MAX_DEGREE = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  crccs_pkg::cfg_t             cfg,
	input  logic                        cfg_clear,
	input  logic                        q_valid,
	input  crccs_pkg::q_entry_t         q_entry,
	output logic                        q_pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic                        m_tuser,
	output logic [crccs_pkg::BYTE_W-1:0] out_byte,
	output logic [crccs_pkg::CNT_W-1:0]  seen,
	output logic [crccs_pkg::CNT_W-1:0]  bad
);
	import crccs_pkg::*;

	localparam int GW  = $clog2(MAX_DEGREE + 1);
	localparam int RW  = MAX_DEGREE;
	localparam int FW  = $clog2(MAX_DEGREE + DW_WIDE + 1);
	localparam int PXW = MAX_DEGREE + 1 + POLY_W;

	logic [RW-1:0]     rem_q;
	logic [FW-1:0]     fill_q;
	logic [BYTE_W-1:0] dw_q;
	logic [3:0]        half_q;
	logic              half_vld_q;
	logic [CNT_W-1:0]  seen_q;
	logic [CNT_W-1:0]  bad_q;
	logic              ovalid_q;
	logic              oflag_q;
	logic [BYTE_W-1:0] obyte_q;

	logic [DEG_W:0]    g_ext;
	logic [GW-1:0]     g;
	logic [FW-1:0]     dlen;
	logic [FW-1:0]     len;
	logic [PXW-1:0]    poly_pad;
	logic [RW:0]       polym;
	logic [RW:0]       gmask;

	logic [RW-1:0]     rem_d;
	logic [FW-1:0]     fill_d;
	logic [BYTE_W-1:0] dw_d;
	logic [3:0]        half_d;
	logic              half_vld_d;
	logic [1:0]        nseen;
	logic [1:0]        nbad;
	logic              oflag_d;
	logic [BYTE_W-1:0] obyte_d;
	logic [CNT_W-1:0]  seen_d;
	logic [CNT_W-1:0]  bad_d;
	logic [CNT_W:0]    seen_sum;
	logic [CNT_W:0]    bad_sum;

	always_comb begin
		g_ext = ({1'b0, cfg.degree} > (DEG_W+1)'(MAX_DEGREE)) ?
			(DEG_W+1)'(MAX_DEGREE) : {1'b0, cfg.degree};
		g        = g_ext[GW-1:0];
		dlen     = cfg.dw8 ? FW'(DW_WIDE) : FW'(DW_NARROW);
		len      = FW'(g) + dlen;
		poly_pad = PXW'(cfg.poly);
		for (int k = 0; k <= RW; k++) begin
			gmask[k] = k < int'(g);
			polym[k] = poly_pad[k] && (k <= int'(g));
		end
	end

	// Eight bit steps of the division, one per stream bit, MSB first.
	always_comb begin
		logic [RW:0]   win;
		logic          b;
		logic [FW-1:0] f_nx;
		rem_d      = rem_q;
		fill_d     = fill_q;
		dw_d       = dw_q;
		half_d     = half_q;
		half_vld_d = half_vld_q;
		nseen      = '0;
		nbad       = '0;
		oflag_d    = 1'b0;
		obyte_d    = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			b    = q_entry.data[BYTE_W-1-i];
			win  = {rem_d, b};
			f_nx = fill_d + FW'(1);
			if (i >= int'(q_entry.skip)) begin
				if ((g != '0) && win[g])
					win = win ^ polym;
				rem_d = win[RW-1:0] & gmask[RW-1:0];
				if (fill_d < dlen)
					dw_d = {dw_d[BYTE_W-2:0], b};
				if (f_nx == len) begin
					nseen = nseen + 2'd1;
					if (rem_d != '0)
						nbad = nbad + 2'd1;
					if (cfg.dw8) begin
						obyte_d = dw_d;
						oflag_d = 1'b1;
					end else if (half_vld_d) begin
						obyte_d    = {half_d, dw_d[3:0]};
						oflag_d    = 1'b1;
						half_vld_d = 1'b0;
					end else begin
						half_d     = dw_d[3:0];
						half_vld_d = 1'b1;
					end
					rem_d  = '0;
					fill_d = '0;
					dw_d   = '0;
				end else begin
					fill_d = f_nx;
				end
			end
		end
		seen_sum = {1'b0, seen_q} + (CNT_W+1)'(nseen);
		bad_sum  = {1'b0, bad_q} + (CNT_W+1)'(nbad);
		seen_d   = seen_sum[CNT_W] ? '1 : seen_sum[CNT_W-1:0];
		bad_d    = bad_sum[CNT_W] ? '1 : bad_sum[CNT_W-1:0];
	end

	assign q_pop    = q_valid && (!ovalid_q || m_tready);
	assign m_tvalid = ovalid_q;
	assign m_tuser  = oflag_q;
	assign out_byte = obyte_q;
	assign seen     = seen_q;
	assign bad      = bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q      <= '0;
			fill_q     <= '0;
			dw_q       <= '0;
			half_q     <= '0;
			half_vld_q <= 1'b0;
			seen_q     <= '0;
			bad_q      <= '0;
			ovalid_q   <= 1'b0;
		end else begin
			if (q_pop)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
			if (cfg_clear || (q_pop && q_entry.hdr)) begin
				rem_q      <= '0;
				fill_q     <= '0;
				dw_q       <= '0;
				half_q     <= '0;
				half_vld_q <= 1'b0;
			end else if (q_pop) begin
				rem_q      <= rem_d;
				fill_q     <= fill_d;
				dw_q       <= dw_d;
				half_q     <= half_d;
				half_vld_q <= half_vld_d;
			end
			if (q_pop) begin
				seen_q <= q_entry.hdr ? '0 : seen_d;
				bad_q  <= q_entry.hdr ? '0 : bad_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			oflag_q <= q_entry.hdr ? 1'b0 : oflag_d;
			obyte_q <= q_entry.hdr ? '0 : obyte_d;
		end
	end

endmodule

// File: rtl/crc_codeword_stream_checker.sv
// Top level of the CRC codeword stream checker: config registers and block wiring.
//
// Channel   Dir  Transfer when         Payload
// s_*       in   s_tvalid & s_tready   tdata: data_byte; tuser: stream_start
// m_*       out  m_tvalid & m_tready   tdata: out_byte, codeword_count, error_count;
//                                      tuser: out_valid
// cfg_*     in   cfg_valid & cfg_ready index 0 poly, 1 degree, 2 dataword_is_8
//
// One byte per cycle unless output stalls; each byte gives one registered result.
// The per-byte path is the eight unrolled bit steps of the CRC division in crccs_back.
// A two-entry queue lets input transfers continue while the output is stalled.
// Reset is asynchronous and returns config to poly 3, degree 1, 8-bit datawords.
// cfg_ready is always high; a write to index 0-2 clears the partial codeword and dataword.
module crc_codeword_stream_checker #(
	parameter int MAX_DEGREE = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [crccs_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
	input  logic                              s_tuser,   // [0] stream_start
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [crccs_pkg::M_TDATA_W-1:0]   m_tdata,   // [7:0] out_byte, [39:8] codeword_count,
	                                                     // [71:40] error_count
	output logic                              m_tuser,   // [0] out_valid
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [crccs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [crccs_pkg::POLY_W-1:0]      cfg_data
);
	import crccs_pkg::*;

	cfg_t              cfg_q;
	logic              cfg_clear;
	logic              q_ready;
	logic              push;
	q_entry_t          entry;
	logic              q_valid;
	logic              q_pop;
	q_entry_t          q_entry;
	logic [BYTE_W-1:0] out_byte;
	logic [CNT_W-1:0]  seen;
	logic [CNT_W-1:0]  bad;

	assign cfg_ready = 1'b1;
	assign cfg_clear = cfg_valid && (cfg_index inside {REG_POLY, REG_DEGREE, REG_DW8});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly   <= POLY_RST;
			cfg_q.degree <= DEGREE_RST;
			cfg_q.dw8    <= DW8_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_POLY:   cfg_q.poly   <= cfg_data;
				REG_DEGREE: cfg_q.degree <= cfg_data[DEG_W-1:0];
				REG_DW8:    cfg_q.dw8    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	crccs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_ready  (q_ready),
		.push     (push),
		.entry    (entry)
	);

	crccs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (entry),
		.ready  (q_ready),
		.pop    (q_pop),
		.dout   (q_entry),
		.valid  (q_valid)
	);

	crccs_back #(
		.MAX_DEGREE (MAX_DEGREE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cfg_clear (cfg_clear),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.out_byte  (out_byte),
		.seen      (seen),
		.bad       (bad)
	);

	assign m_tdata = {bad, seen, out_byte};

endmodule

// File: rtl/crccs_checker.sv
// Port-level assertions for the CRC codeword stream checker, bound to the top level.
module crccs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [crccs_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                            m_tuser
);
	import crccs_pkg::*;

	logic [CNT_W-1:0] seen;
	logic [CNT_W-1:0] bad;

	assign seen = m_tdata[BYTE_W+CNT_W-1:BYTE_W];
	assign bad  = m_tdata[M_TDATA_W-1:BYTE_W+CNT_W];

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[BYTE_W-1:0] == '0)
		else $error("out_byte nonzero without out_valid");

	a_bad_le_seen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> bad <= seen)
		else $error("error count above codeword count");

	a_seen_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) ##1 (m_tvalid && m_tready) |->
		seen == '0 || (seen >= $past(seen) && seen - $past(seen) <= CNT_W'(2)))
		else $error("codeword count stepped by more than two");

endmodule

bind crc_codeword_stream_checker crccs_checker u_chk (.*);
